// ----- design/vvpo_pkg.sv -----
// Shared types, constants and helper functions for the voice volume/pan block.
// Depends on nothing; used by voice_volume_pan_output_top.
`timescale 1ns / 1ps

package vvpo_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_LOG_MODE  = 2'd0;
  localparam logic [1:0] CFG_PAN_SCALE = 2'd1;
  localparam logic [1:0] CFG_CHANNEL   = 2'd2;

  // Reset values of the configuration registers
  localparam logic       LOG_MODE_RESET  = 1'b0;
  localparam logic [6:0] PAN_SCALE_RESET = 7'd100;
  localparam logic [4:0] CHANNEL_RESET   = 5'd0;

  // Pan constants
  localparam logic [7:0]        PAN_CENTER   = 8'd128;
  localparam logic signed [7:0] ENV_PAN_MID  = 8'sd32;
  localparam logic [7:0]        SAT_MAX      = 8'd255;
  localparam logic [7:0]        VOL_ONLY     = 8'd255;
  localparam logic [3:0]        BAL_OFFSET   = 4'd7;
  localparam logic signed [9:0] BAL_BIAS     = 10'sd240;

  // Reciprocal of 100: m * 5243 >> 19 is exact for m below 16384
  localparam logic [26:0] PCT_RECIP = 27'd5243;

  // Command flags that travel with each request
  typedef struct packed {
    logic       pan;
    logic       balance;
    logic       start;
    logic       note_chg;
    logic       key_off;
    logic [6:0] note;
  } flags_t;

  // Expand an 8-bit level through the 4.4 exponent/mantissa curve,
  // filling below the mantissa when the exponent is 4 or more, and keep the upper byte
  function automatic logic [7:0] log_curve(input logic [7:0] v);
    logic [3:0]  ex;
    logic [3:0]  man;
    logic [15:0] w;
    logic [3:0]  sh;
    ex  = v[7:4];
    man = v[3:0];
    w   = 16'd1 << ex;
    if (ex >= 4'd4) begin
      sh = ex - 4'd4;
      w  = w | ({12'd0, man} << sh);
      w  = w | ((16'd1 << sh) - 16'd1);
    end else begin
      sh = 4'd4 - ex;
      w  = w | ({12'd0, man} >> sh);
    end
    return w[15:8];
  endfunction

  // Clamp a signed value to 0..255
  function automatic logic [7:0] clamp_u8(input logic signed [11:0] x);
    logic [7:0] r;
    if (x < 12'sd0) begin
      r = 8'd0;
    end else if (x > 12'sd255) begin
      r = SAT_MAX;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

endpackage

// ----- design/voice_volume_pan_output_top.sv -----
// Voice volume and pan command generator, five-stage pipeline.
// Depends on vvpo_pkg (scoped references only).
`timescale 1ns / 1ps

// Usage:
//   Request channel: req_valid / req_stall with one voice's mix parameters
//   and change mask. A request is taken at a clock edge with req_valid high
//   and req_stall low. Requests that are delayed or carry an empty change
//   mask are taken and dropped; they yield no result.
//   Result channel: res_valid / res_stall with the voice commands. Fields of
//   a command that is absent read as zero.
//   Configuration: cfg_write with cfg_index and cfg_data; write only while
//   no request is in flight.
//   Stages: multiply, add and saturate, divide by 255 and pan magnitude
//   scale, curve and reciprocal multiply, balance and output register.
//   Throughput: one request per cycle while req_stall is low; every stage is one register deep.
//   Stall: res_stall holds the output register; earlier stages keep moving
//   into empty slots, so req_stall rises only once the pipeline is full.
//   Reset: rst clears all stage valid bits and loads the register defaults
//   (linear volume, pan scale 100, voice 0).
module voice_volume_pan_output_top (
  input  logic       clk,
  input  logic       rst,
  // configuration port
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  // request channel
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [6:0] note_volume,
  input  logic [6:0] envelope_volume,
  input  logic [7:0] tremolo_offset,
  input  logic       tremor_gate,
  input  logic [7:0] master_volume,
  input  logic [7:0] pan_position,
  input  logic [6:0] envelope_pan,
  input  logic [6:0] note_number,
  input  logic [3:0] change_mask,
  input  logic       note_delayed,
  // result channel
  output logic       res_valid,
  input  logic       res_stall,
  output logic [4:0] channel_out,
  output logic       pan_valid,
  output logic [7:0] pan_out,
  output logic       balance_valid,
  output logic [3:0] balance_out,
  output logic       start_valid,
  output logic [7:0] start_note,
  output logic [7:0] volume_out,
  output logic       key_off
);

  // Configuration registers
  logic       log_mode;
  logic [6:0] pan_scale;
  logic [4:0] channel;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_mode  <= vvpo_pkg::LOG_MODE_RESET;
      pan_scale <= vvpo_pkg::PAN_SCALE_RESET;
      channel   <= vvpo_pkg::CHANNEL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        vvpo_pkg::CFG_LOG_MODE:  log_mode  <= cfg_data[0];
        vvpo_pkg::CFG_PAN_SCALE: pan_scale <= cfg_data;
        vvpo_pkg::CFG_CHANNEL:   channel   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and advance enables; bubbles are squeezed out
  logic a_valid, b_valid, c_valid, d_valid, e_valid;
  logic en_a, en_b, en_c, en_d, en_e;

  assign en_e      = !e_valid || !res_stall;
  assign en_d      = !d_valid || en_e;
  assign en_c      = !c_valid || en_d;
  assign en_b      = !b_valid || en_c;
  assign en_a      = !a_valid || en_b;
  assign req_stall = !en_a;

  logic a_emit;
  assign a_emit = req_valid && !note_delayed && (change_mask != 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      if (en_a) a_valid <= a_emit;
      if (en_b) b_valid <= a_valid;
      if (en_c) c_valid <= b_valid;
      if (en_d) d_valid <= c_valid;
      if (en_e) e_valid <= d_valid;
    end
  end

  // ---------------- Stage A: products ----------------
  vvpo_pkg::flags_t    a_flags, b_flags, c_flags, d_flags, e_flags;
  vvpo_pkg::flags_t    a_flags_next;
  logic [13:0]         a_vprod;
  logic [7:0]          a_tr;
  logic                a_gate;
  logic [7:0]          a_mv;
  logic [7:0]          a_pan;
  logic signed [15:0]  a_pan_mul;

  logic [7:0]          pan_dist;
  logic signed [8:0]   pan_room;
  logic signed [7:0]   env_dev;
  logic signed [16:0]  pan_mul_full;

  // Build flags and the pan envelope product
  always_comb begin
    a_flags_next.pan      = change_mask[0];
    a_flags_next.balance  = change_mask[0] && !change_mask[1];
    a_flags_next.start    = change_mask[1] || change_mask[2];
    a_flags_next.note_chg = change_mask[1];
    a_flags_next.key_off  = change_mask[3];
    a_flags_next.note     = note_number;
    pan_dist = (pan_position >= vvpo_pkg::PAN_CENTER) ?
               (pan_position - vvpo_pkg::PAN_CENTER) :
               (vvpo_pkg::PAN_CENTER - pan_position);
    pan_room = $signed({1'b0, vvpo_pkg::PAN_CENTER}) - $signed({1'b0, pan_dist});
    env_dev  = $signed({1'b0, envelope_pan}) - vvpo_pkg::ENV_PAN_MID;
    pan_mul_full = env_dev * pan_room;
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_flags   <= a_flags_next;
      a_vprod   <= {7'd0, note_volume} * {7'd0, envelope_volume};
      a_tr      <= tremolo_offset;
      a_gate    <= tremor_gate;
      a_mv      <= master_volume;
      a_pan     <= pan_position;
      a_pan_mul <= pan_mul_full[15:0];
    end
  end

  // ---------------- Stage B: volume gain, pan modulation ----------------
  logic [16:0]         b_vmul;
  logic [7:0]          b_pan;
  logic [8:0]          vsum;
  logic signed [15:0]  pan_adj;
  logic signed [15:0]  pan_div;
  logic signed [11:0]  pan_sum;

  always_comb begin
    vsum    = {1'b0, a_vprod[13:6]} + {1'b0, a_tr};
    // truncate toward zero
    pan_adj = a_pan_mul + (a_pan_mul[15] ? 16'sd31 : 16'sd0);
    pan_div = pan_adj >>> 5;
    pan_sum = $signed({4'd0, a_pan}) + $signed(pan_div[11:0]);
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_flags <= a_flags;
      b_vmul  <= a_gate ? ({8'd0, vsum} * {9'd0, a_mv}) : 17'd0;
      b_pan   <= vvpo_pkg::clamp_u8(pan_sum);
    end
  end

  // ---------------- Stage C: divide by 255, pan magnitude scale ----------------
  logic [7:0]         c_vol;
  logic [13:0]        c_smag;
  logic               c_neg;
  logic [8:0]         div_est;
  logic [9:0]         div_rem;
  logic [9:0]         div_q;
  logic signed [8:0]  pan_dev;
  logic signed [8:0]  pan_dev_neg;
  logic [7:0]         pan_mag;

  always_comb begin
    // floor(x/256) under-counts by at most two against x/255
    div_est = b_vmul[16:8];
    div_rem = {2'd0, b_vmul[7:0]} + {1'b0, div_est};
    div_q   = {1'b0, div_est}
            + ((div_rem >= 10'd255) ? 10'd1 : 10'd0)
            + ((div_rem >= 10'd510) ? 10'd1 : 10'd0);
    pan_dev     = $signed({1'b0, b_pan}) - $signed({1'b0, vvpo_pkg::PAN_CENTER});
    pan_dev_neg = -pan_dev;
    pan_mag     = pan_dev[8] ? pan_dev_neg[7:0] : pan_dev[7:0];
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_flags <= b_flags;
      c_vol   <= (div_q > 10'd255) ? vvpo_pkg::SAT_MAX : div_q[7:0];
      c_smag  <= {6'd0, pan_mag} * {7'd0, pan_scale};
      c_neg   <= pan_dev[8];
    end
  end

  // ---------------- Stage D: volume curve, pan percent ----------------
  logic [7:0]         d_vol;
  logic [7:0]         d_pan;
  logic [26:0]        pct_prod;
  logic [7:0]         pct_q;
  logic signed [11:0] pan_scaled;

  always_comb begin
    pct_prod   = {13'd0, c_smag} * vvpo_pkg::PCT_RECIP;
    pct_q      = pct_prod[26:19];
    pan_scaled = c_neg ?
                 ($signed({4'd0, vvpo_pkg::PAN_CENTER}) - $signed({4'd0, pct_q})) :
                 ($signed({4'd0, vvpo_pkg::PAN_CENTER}) + $signed({4'd0, pct_q}));
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_flags <= c_flags;
      d_vol   <= log_mode ? vvpo_pkg::log_curve(c_vol) : {1'b0, c_vol[7:1]};
      d_pan   <= vvpo_pkg::clamp_u8(pan_scaled);
    end
  end

  // ---------------- Stage E: balance and output register ----------------
  logic [7:0]         e_pan;
  logic [7:0]         e_vol;
  logic [3:0]         e_bal;
  logic signed [9:0]  bal_x;
  logic signed [9:0]  bal_adj;
  logic signed [9:0]  bal_div;
  logic [3:0]         bal;

  always_comb begin
    bal_x   = $signed({1'b0, d_pan, 1'b0}) - vvpo_pkg::BAL_BIAS;
    bal_adj = bal_x + (bal_x[9] ? 10'sd31 : 10'sd0);
    bal_div = bal_adj >>> 5;
    bal     = bal_div[3:0] + vvpo_pkg::BAL_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      e_flags <= d_flags;
      e_pan   <= d_pan;
      e_vol   <= d_vol;
      e_bal   <= bal;
    end
  end

  // Drive result fields; absent commands read as zero
  assign res_valid     = e_valid;
  assign channel_out   = channel;
  assign pan_valid     = e_flags.pan;
  assign pan_out       = e_flags.pan ? e_pan : 8'd0;
  assign balance_valid = e_flags.balance;
  assign balance_out   = e_flags.balance ? e_bal : 4'd0;
  assign start_valid   = e_flags.start;
  assign start_note    = !e_flags.start ? 8'd0 :
                         (e_flags.note_chg ? {1'b0, e_flags.note} : vvpo_pkg::VOL_ONLY);
  assign volume_out    = e_flags.start ? e_vol : 8'd0;
  assign key_off       = e_flags.key_off;

endmodule
